// ===== src/wfhp_pkg.sv =====
// Package for the 802.11 frame header parser: request/result types,
// register indexes, header offsets and the LLC/SNAP byte pattern.
// No dependencies.
package wfhp_pkg;

  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 12;
  localparam int ADDR_W       = 48;
  localparam int KIND_W       = 3;
  localparam int ETYPE_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int HEADER_BYTES = 24;
  localparam int HIST_BYTES   = 7;
  localparam int ADDR_BYTES   = 6;
  localparam int ADDR_CELLS   = 3 * ADDR_BYTES;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 12'd4095;
  localparam logic [COUNT_W-1:0] ADDR_FIRST   = 12'd4;
  localparam logic [COUNT_W-1:0] ADDR_END     = ADDR_FIRST + COUNT_W'(ADDR_CELLS);
  localparam logic [COUNT_W-1:0] HDR_LEN      = COUNT_W'(HEADER_BYTES);
  // earliest offset of the final ethertype byte of a match
  localparam logic [COUNT_W-1:0] MATCH_FIRST  = COUNT_W'(HEADER_BYTES + HIST_BYTES);

  localparam logic [COUNT_W-1:0] LIMIT_RESET  = 12'd64;
  localparam logic [ETYPE_W-1:0] ETYPE_RESET  = 16'h888E;

  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ETHERTYPE = 2'd1;

  localparam logic [KIND_W-1:0] KIND_MGMT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CTRL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EAPOL   = 3'd4;

  localparam logic [BYTE_W-1:0] SNAP_AA   = 8'hAA;
  localparam logic [BYTE_W-1:0] SNAP_CTRL = 8'h03;
  localparam logic [BYTE_W-1:0] SNAP_ZERO = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frame_length;
    logic [KIND_W-1:0]  frame_kind;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ADDR_W-1:0]  source_addr;
    logic [ADDR_W-1:0]  bss_addr;
    logic               eapol_found;
  } out_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_one;
    logic [ADDR_W-1:0] addr_two;
    logic [ADDR_W-1:0] addr_three;
  } addr_set_t;

  // Pattern byte expected in history cell k (k = 0 holds the previous byte).
  function automatic logic [BYTE_W-1:0] hist_expect(input int k,
                                                    input logic [BYTE_W-1:0] etype_hi);
    logic [BYTE_W-1:0] b;
    case (k)
      0:       b = etype_hi;
      1, 2, 3: b = SNAP_ZERO;
      4:       b = SNAP_CTRL;
      default: b = SNAP_AA;
    endcase
    return b;
  endfunction

  function automatic logic [KIND_W-1:0] kind_of(input logic [COUNT_W-1:0] len,
                                                input logic [BYTE_W-1:0]  fc);
    logic [KIND_W-1:0] k;
    if (len < COUNT_W'(2)) begin
      k = KIND_UNKNOWN;
    end else begin
      case (fc[3:2])
        2'd0:    k = KIND_MGMT;
        2'd1:    k = KIND_CTRL;
        2'd2:    k = KIND_DATA;
        default: k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage

// ===== src/wifi_frame_header_parser.sv =====
// 802.11 MAC header parser with EAPOL detection, top level.
// Uses wfhp_pkg, wfhp_match_cell and wfhp_addr_chain.
//
// Usage: frame bytes arrive on the in_ channel, one request per byte, with
// last_byte set on the final byte. One result per frame leaves on the out_
// channel: length, kind, the three addresses and the EAPOL flag.
// Throughput is one byte per cycle while no final byte is held back; the
// byte count and all pattern compares are done in the accepting cycle, so
// the limit is the single count/compare step per byte.
// Latency: the result is valid the cycle after the last byte is accepted.
// A result register sits between the channels; while it is full and the
// receiver stalls, bytes that do not end a frame are still taken and only a
// final byte is held back.
// Configuration (cfg_) writes take effect at once; write only while idle.
// Reset sets search_limit to 64, match_ethertype to 0x888E, clears the
// frame state and empties the result register. No clearing pass is needed.
module wifi_frame_header_parser
  import wfhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  logic [COUNT_W-1:0] limit_r;
  logic [ETYPE_W-1:0] etype_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               seen_r, seen_nxt;
  logic [BYTE_W-1:0]  fc_r;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_res_r, res_nxt;

  logic               accept, counting, addr_en, match_now;
  logic [BYTE_W-1:0]  hist_byte [HIST_BYTES+1];
  logic [HIST_BYTES-1:0] hist_hit;
  addr_set_t          addrs;

  assign in_stall = out_valid_r && out_stall && in_req.last_byte;
  assign accept   = in_valid && !in_stall;
  assign counting = (count_r != COUNT_MAX);
  assign addr_en  = accept && counting && (count_r >= ADDR_FIRST) && (count_r < ADDR_END);

  // history line: cell 0 holds the previous byte
  assign hist_byte[0] = in_req.data_byte;
  for (genvar k = 0; k < HIST_BYTES; k++) begin : g_hist
    wfhp_match_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (hist_byte[k]),
      .exp_byte (hist_expect(k, etype_r[ETYPE_W-1 -: BYTE_W])),
      .byte_out (hist_byte[k+1]),
      .hit      (hist_hit[k])
    );
  end

  wfhp_addr_chain u_addr (
    .clk      (clk),
    .shift_en (addr_en),
    .byte_in  (in_req.data_byte),
    .addrs    (addrs)
  );

  assign match_now = counting && (count_r >= MATCH_FIRST) && (count_r < limit_r) &&
                     (&hist_hit) && (in_req.data_byte == etype_r[BYTE_W-1:0]);

  always_comb begin
    count_nxt = counting ? count_r + COUNT_W'(1) : count_r;
    seen_nxt  = seen_r || match_now;

    res_nxt.frame_length = count_nxt;
    res_nxt.frame_kind   = seen_nxt ? KIND_EAPOL : kind_of(count_nxt, fc_r);
    res_nxt.eapol_found  = seen_nxt;
    if (count_nxt < HDR_LEN) begin
      res_nxt.dest_addr   = '0;
      res_nxt.source_addr = '0;
      res_nxt.bss_addr    = '0;
    end else begin
      res_nxt.dest_addr   = addrs.addr_one;
      res_nxt.source_addr = addrs.addr_two;
      res_nxt.bss_addr    = addrs.addr_three;
    end

    if (accept && in_req.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      etype_r     <= ETYPE_RESET;
      count_r     <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEARCH_LIMIT:    limit_r <= cfg_wr_data[COUNT_W-1:0];
          CFG_MATCH_ETHERTYPE: etype_r <= cfg_wr_data[ETYPE_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        count_r <= in_req.last_byte ? '0 : count_nxt;
        seen_r  <= in_req.last_byte ? 1'b0 : seen_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame control byte and result payload need no reset
  always_ff @(posedge clk) begin
    if (accept && count_r == '0) begin
      fc_r <= in_req.data_byte;
    end
    if (accept && in_req.last_byte) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/wfhp_match_cell.sv =====
// One byte cell of the history line: holds a byte, passes it on each
// shift and compares it with its pattern byte. Uses wfhp_pkg.
module wfhp_match_cell
  import wfhp_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [BYTE_W-1:0] exp_byte,
  output logic [BYTE_W-1:0] byte_out,
  output logic              hit
);

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = (byte_r == exp_byte);

endmodule

// ===== src/wfhp_addr_chain.sv =====
// Row of byte cells that captures header bytes 4..21 and presents them as
// the three station addresses. Uses wfhp_pkg.
module wfhp_addr_chain
  import wfhp_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  output addr_set_t         addrs
);

  // cell 0 takes the newest byte, cell ADDR_CELLS-1 holds byte 4
  logic [BYTE_W-1:0] cell_r [ADDR_CELLS];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      cell_r[0] <= byte_in;
    end
  end

  for (genvar i = 1; i < ADDR_CELLS; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (shift_en) begin
        cell_r[i] <= cell_r[i-1];
      end
    end
  end

  for (genvar j = 0; j < ADDR_BYTES; j++) begin : g_tap
    // first byte of each address lands in the most significant position
    assign addrs.addr_one[ADDR_W-1-BYTE_W*j -: BYTE_W]   = cell_r[ADDR_CELLS-1-j];
    assign addrs.addr_two[ADDR_W-1-BYTE_W*j -: BYTE_W]   = cell_r[ADDR_CELLS-1-ADDR_BYTES-j];
    assign addrs.addr_three[ADDR_W-1-BYTE_W*j -: BYTE_W] =
      cell_r[ADDR_CELLS-1-2*ADDR_BYTES-j];
  end

endmodule

// ===== src/wfhp_checker.sv =====
// Port-level checks for wifi_frame_header_parser, attached by bind.
// Uses wfhp_pkg.
module wfhp_checker
  import wfhp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_res
);

  // a held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // a new result follows only a final-byte request
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_req.last_byte))
    else $error("result without a final byte");

  // EAPOL flag and kind agree
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.eapol_found == (out_res.frame_kind == KIND_EAPOL)) &&
                  (out_res.frame_kind <= KIND_EAPOL))
    else $error("kind and EAPOL flag disagree");

  // short frames carry no addresses and no match
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.frame_length < HDR_LEN |->
      out_res.dest_addr == '0 && out_res.source_addr == '0 &&
      out_res.bss_addr == '0 && !out_res.eapol_found)
    else $error("short frame with address or match");

endmodule

bind wifi_frame_header_parser wfhp_checker u_wfhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
